// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AV_ASSERT(lbl, prop)
`define AV_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/avel_pkg.sv =====
// Shared types and constants for the arrive velocity block.
`timescale 1ns / 1ps
package avel_pkg;

    localparam int TIME_FRAC  = 8;
    localparam int TIME_WIDTH = 16;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_TIME   = 2'd1;
    localparam logic [1:0] CFG_SPEED  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_SQR,
        ST_CMP,
        ST_SQRT,
        ST_MULX,
        ST_DIVSX,
        ST_DIVSY,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/avel_front.sv =====
// Front pipeline: offsets, squared length and the arrive test.
`timescale 1ns / 1ps
module avel_front #(
    parameter int W = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  target_x,
    input  logic signed [W-1:0]  target_y,
    input  logic signed [W-1:0]  own_x,
    input  logic signed [W-1:0]  own_y,
    input  logic [W-2:0]         radius,
    output logic                 push,
    input  logic                 full,
    output logic [2*W+2:0]       push_data
);

    logic               s1_valid_reg;
    logic signed [W:0]  dx_reg, dy_reg;
    logic               s2_valid_reg;
    logic signed [W:0]  dx2_reg, dy2_reg;
    logic [2*W+1:0]     sqx_reg, sqy_reg;
    logic [2*W-3:0]     rad_sq_reg;
    logic [W:0]         ax, ay;
    logic [2*W+2:0]     len_sq;
    logic               adv1, adv2, hold;

    assign adv2     = !s2_valid_reg || !full;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign push     = s2_valid_reg && !full;

    assign ax = dx_reg[W] ? (W+1)'(-dx_reg) : (W+1)'(dx_reg);
    assign ay = dy_reg[W] ? (W+1)'(-dy_reg) : (W+1)'(dy_reg);

    assign len_sq    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hold      = len_sq < (2*W+3)'(rad_sq_reg);
    assign push_data = {hold, dy2_reg, dx2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_sq_reg <= radius * radius;
        if (adv1)
        begin
            dx_reg <= (W+1)'(target_x) - (W+1)'(own_x);
            dy_reg <= (W+1)'(target_y) - (W+1)'(own_y);
        end
        if (adv2)
        begin
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
        end
    end

endmodule

// ===== rtl/avel_fifo.sv =====
// Small request queue between front and back.
`timescale 1ns / 1ps
module avel_fifo #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [4];
    logic [1:0]    wptr_reg, rptr_reg;
    logic [2:0]    cnt_reg;

    assign full      = cnt_reg == 3'd4;
    assign not_empty = cnt_reg != 3'd0;
    assign rdata     = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 2'd1;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

// ===== rtl/avel_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module avel_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DW-1:0]             num_hi,
    input  logic [NW-1:0]             num_lo,
    input  logic [$clog2(NW+1)-1:0]   nbits,
    input  logic [DW-1:0]             den,
    output logic                      busy,
    output logic                      done,
    output logic [NW-1:0]             quo
);

    localparam int CW = $clog2(NW+1);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] work_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   rem2, diff;
    logic          qbit;

    assign rem2 = {rem_reg, work_reg[NW-1]};
    assign qbit = rem2 >= {1'b0, den};
    assign diff = rem2 - {1'b0, den};
    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_hi;
            work_reg <= num_lo;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? diff[DW-1:0] : rem2[DW-1:0];
            work_reg <= {work_reg[NW-2:0], 1'b0};
            quo_reg  <= {quo_reg[NW-2:0], qbit};
        end
    end

endmodule

// ===== rtl/avel_back.sv =====
// Back end: divide by time, speed test, square root and rescale.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module avel_back #(
    parameter int W = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  logic [2*W+2:0]      q_data,
    output logic                pop,
    input  logic [15:0]         ttt,
    input  logic [W-2:0]        max_speed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [W-1:0]        vel_x,
    output logic [W-1:0]        vel_y,
    output logic                hold
);

    localparam int NW  = 2*W;
    localparam int DW  = (W > avel_pkg::TIME_WIDTH) ? W : avel_pkg::TIME_WIDTH;
    localparam int CW  = $clog2(NW+1);
    localparam int QW  = W + 1 + avel_pkg::TIME_FRAC;
    localparam int SCW = $clog2(W+1);
    localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (W-1)) - 64'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (W-1));

    avel_pkg::state_t state_reg, state_next;

    logic              sx_reg, sy_reg, hold_reg;
    logic [W:0]        ay_reg;
    logic [W-1:0]      mx_reg, my_reg, root_reg;
    logic [2*W-1:0]    sqx_reg, sqy_reg, spd_reg, x_reg, prody_reg;
    logic [W+2:0]      rem_reg;
    logic [SCW-1:0]    cnt_reg;
    logic [W-1:0]      resx_reg, resy_reg;
    logic              m_valid_reg;
    logic [W-1:0]      vx_reg, vy_reg;
    logic              h_reg;

    logic signed [W:0] qdx, qdy;
    logic [W:0]        qax, qay;
    logic              start, div_busy, div_done;
    logic [DW-1:0]     num_hi, den;
    logic [NW-1:0]     num_lo, quo, prodx;
    logic [CW-1:0]     nbits;
    logic [W-1:0]      qsat;
    logic [QW-1:0]     qlow;
    logic [2*W:0]      s_sum;
    logic [W+2:0]      rem2, trial;
    logic              take_out;

    assign qdx = q_data[W:0];
    assign qdy = q_data[2*W+1:W+1];
    assign qax = qdx[W] ? (W+1)'(-qdx) : (W+1)'(qdx);
    assign qay = qdy[W] ? (W+1)'(-qdy) : (W+1)'(qdy);

    assign den   = (state_reg == avel_pkg::ST_MULX || state_reg == avel_pkg::ST_DIVSX ||
                    state_reg == avel_pkg::ST_DIVSY) ? DW'(root_reg) :
                   ((ttt == 16'd0) ? DW'(1) : DW'(ttt));
    assign prodx = NW'(mx_reg * max_speed);
    assign qlow  = quo[QW-1:0];
    assign s_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign rem2  = {rem_reg[W:0], x_reg[2*W-1:2*W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign take_out = !m_valid_reg || m_ready;
    assign pop   = (state_reg == avel_pkg::ST_IDLE) && q_valid;

    // saturate the time quotient by sign; magnitude of the negative limit is one larger
    always_comb
    begin
        if (state_reg == avel_pkg::ST_DIVX)
            qsat = W'(sx_reg ? ((qlow > NEG_LIM) ? NEG_LIM : qlow)
                             : ((qlow > POS_LIM) ? POS_LIM : qlow));
        else
            qsat = W'(sy_reg ? ((qlow > NEG_LIM) ? NEG_LIM : qlow)
                             : ((qlow > POS_LIM) ? POS_LIM : qlow));
    end

    always_comb
    begin
        start  = 1'b0;
        num_hi = '0;
        num_lo = '0;
        nbits  = CW'(QW);
        unique case (state_reg)
            avel_pkg::ST_IDLE:
            begin
                start  = q_valid && !q_data[2*W+2];
                num_lo = {qax, {(NW-W-1){1'b0}}};
            end
            avel_pkg::ST_DIVX:
            begin
                start  = div_done;
                num_lo = {ay_reg, {(NW-W-1){1'b0}}};
            end
            avel_pkg::ST_MULX:
            begin
                start  = 1'b1;
                nbits  = CW'(W-1);
                num_hi = DW'(prodx >> (W-1));
                num_lo = prodx << (W+1);
            end
            avel_pkg::ST_DIVSX:
            begin
                start  = div_done;
                nbits  = CW'(W-1);
                num_hi = DW'(prody_reg >> (W-1));
                num_lo = prody_reg << (W+1);
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            avel_pkg::ST_IDLE:
                if (q_valid)
                    state_next = q_data[2*W+2] ? avel_pkg::ST_OUT : avel_pkg::ST_DIVX;
            avel_pkg::ST_DIVX:
                if (div_done)
                    state_next = avel_pkg::ST_DIVY;
            avel_pkg::ST_DIVY:
                if (div_done)
                    state_next = avel_pkg::ST_SQR;
            avel_pkg::ST_SQR:
                state_next = avel_pkg::ST_CMP;
            avel_pkg::ST_CMP:
                state_next = (s_sum > {1'b0, spd_reg}) ? avel_pkg::ST_SQRT : avel_pkg::ST_OUT;
            avel_pkg::ST_SQRT:
                if (cnt_reg == SCW'(1))
                    state_next = avel_pkg::ST_MULX;
            avel_pkg::ST_MULX:
                state_next = avel_pkg::ST_DIVSX;
            avel_pkg::ST_DIVSX:
                if (div_done)
                    state_next = avel_pkg::ST_DIVSY;
            avel_pkg::ST_DIVSY:
                if (div_done)
                    state_next = avel_pkg::ST_OUT;
            avel_pkg::ST_OUT:
                if (take_out)
                    state_next = avel_pkg::ST_IDLE;
            default:
                state_next = avel_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= avel_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == avel_pkg::ST_OUT && take_out)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            avel_pkg::ST_IDLE:
            begin
                sx_reg   <= qdx[W];
                sy_reg   <= qdy[W];
                ay_reg   <= qay;
                hold_reg <= q_data[2*W+2];
                resx_reg <= '0;
                resy_reg <= '0;
            end
            avel_pkg::ST_DIVX:
                if (div_done)
                    mx_reg <= qsat;
            avel_pkg::ST_DIVY:
                if (div_done)
                    my_reg <= qsat;
            avel_pkg::ST_SQR:
            begin
                sqx_reg <= mx_reg * mx_reg;
                sqy_reg <= my_reg * my_reg;
                spd_reg <= NW'(max_speed * max_speed);
            end
            avel_pkg::ST_CMP:
            begin
                resx_reg <= sx_reg ? W'(-mx_reg) : mx_reg;
                resy_reg <= sy_reg ? W'(-my_reg) : my_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                x_reg    <= s_sum[2*W-1:0];
                cnt_reg  <= SCW'(W);
            end
            avel_pkg::ST_SQRT:
            begin
                // two radicand bits per step
                if (rem2 >= trial)
                begin
                    rem_reg  <= rem2 - trial;
                    root_reg <= {root_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem2;
                    root_reg <= {root_reg[W-2:0], 1'b0};
                end
                x_reg   <= {x_reg[2*W-3:0], 2'b00};
                cnt_reg <= cnt_reg - SCW'(1);
            end
            avel_pkg::ST_MULX:
                prody_reg <= NW'(my_reg * max_speed);
            avel_pkg::ST_DIVSX:
                if (div_done)
                    resx_reg <= sx_reg ? W'(-quo[W-1:0]) : quo[W-1:0];
            avel_pkg::ST_DIVSY:
                if (div_done)
                    resy_reg <= sy_reg ? W'(-quo[W-1:0]) : quo[W-1:0];
            avel_pkg::ST_OUT:
                if (take_out)
                begin
                    vx_reg <= resx_reg;
                    vy_reg <= resy_reg;
                    h_reg  <= hold_reg;
                end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    avel_div #(.NW(NW), .DW(DW)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .num_hi (num_hi),
        .num_lo (num_lo),
        .nbits  (nbits),
        .den    (den),
        .busy   (div_busy),
        .done   (div_done),
        .quo    (quo)
    );

    assign m_valid = m_valid_reg;
    assign vel_x   = vx_reg;
    assign vel_y   = vy_reg;
    assign hold    = h_reg;

    `AV_ASSERT(a_hold_zero, m_valid && hold |-> vel_x == '0 && vel_y == '0)
    `AV_ASSERT(a_pop_idle, pop |-> state_reg == avel_pkg::ST_IDLE)
    `AV_ASSERT(a_start_free, start |-> !div_busy)

endmodule

// ===== rtl/arrive_velocity_2d.sv =====
// Top level of the arrive velocity block: config registers and wiring.
//
// Use: positions enter on the s_ stream (target_x, target_y, own_x, own_y,
// signed, packed from bit 0). Each request yields one result on the m_
// stream: vel_x, vel_y in m_tdata, the hold flag in m_tuser.
// Configuration writes go on cfg_valid/cfg_addr/cfg_data (0 radius, 1 time
// to target, 2 max speed) and are always accepted; write them while idle.
// A two-stage front forms offsets and the arrive test and fills a four-deep
// queue; it takes one request per cycle until the queue backs up.
// The back end handles one request at a time on one shared bit-serial
// divider: a hold request goes straight to the output, a moving request
// divides both offsets by the time to target, and when the speed limit
// applies it also runs the square root loop and divides both again.
// Requests reach the back end through the two front stages and the queue.
// Reset clears the valid flags, state and queue; config registers take
// their defaults. When m_tready is low the result is held in the output
// register and the front keeps accepting until the queue is full.
`timescale 1ns / 1ps
module arrive_velocity_2d #(
    parameter int POS_WIDTH = 24,
    localparam int IN_W  = ((4*POS_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2*POS_WIDTH + 7) / 8) * 8,
    localparam int CFG_W = (POS_WIDTH - 1 > 16) ? POS_WIDTH - 1 : 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // target_x, target_y, own_x, own_y
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // vel_x, vel_y
    output logic             m_tuser,   // hold
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int W  = POS_WIDTH;
    localparam int EW = 2*W + 3;

    logic [W-2:0]   radius_reg, speed_reg;
    logic [15:0]    ttt_reg;
    logic           push, full, q_valid, pop;
    logic [EW-1:0]  push_data, q_data;
    logic [W-1:0]   vel_x, vel_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            ttt_reg    <= 16'd256;
            speed_reg  <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                avel_pkg::CFG_RADIUS: radius_reg <= cfg_data[W-2:0];
                avel_pkg::CFG_TIME:   ttt_reg    <= cfg_data[15:0];
                avel_pkg::CFG_SPEED:  speed_reg  <= cfg_data[W-2:0];
                default:              ttt_reg    <= ttt_reg;
            endcase
        end
    end

    avel_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .target_x  (s_tdata[W-1:0]),
        .target_y  (s_tdata[2*W-1:W]),
        .own_x     (s_tdata[3*W-1:2*W]),
        .own_y     (s_tdata[4*W-1:3*W]),
        .radius    (radius_reg),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    avel_fifo #(.DW(EW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .rdata     (q_data)
    );

    avel_back #(.W(W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .ttt       (ttt_reg),
        .max_speed (speed_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .hold      (m_tuser)
    );

    assign m_tdata = OUT_W'({vel_y, vel_x});

endmodule

// ===== test/tb_arrive_velocity_2d.sv =====
// Self-checking testbench for the arrive velocity block.
`timescale 1ns / 1ps
module tb_arrive_velocity_2d;

    localparam int W     = 24;
    localparam int IN_W  = 96;
    localparam int OUT_W = 48;
    localparam int CFG_W = 23;
    localparam longint PMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint PMIN = -PMAX - 1;

    typedef struct packed {
        logic signed [W-1:0] oy;
        logic signed [W-1:0] ox;
        logic signed [W-1:0] ty;
        logic signed [W-1:0] tx;
    } pos_req_t;

    typedef struct packed {
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic                hold;
    } vel_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_data;

    arrive_velocity_2d #(.POS_WIDTH(W)) dut (.*);

    // shadow of the config registers
    longint unsigned radius_r, ttt_r, speed_r;

    pos_req_t pending_reqs[$];
    vel_t     expected_vel[$];
    int errors, results_seen, holds_seen;
    int src_idle_pct, snk_idle_pct;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > PMAX) return PMAX;
        if (v < PMIN) return PMIN;
        return v;
    endfunction

    function automatic longint scale_trunc(longint num, longint unsigned mul,
                                           longint unsigned den);
        longint unsigned q;
        q = (abs64(num) * mul) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vel_t arrive_velocity(pos_req_t p);
        vel_t v;
        longint dx, dy, vx, vy;
        longint unsigned len_sq, s, t, l;
        dx = longint'(p.tx) - longint'(p.ox);
        dy = longint'(p.ty) - longint'(p.oy);
        len_sq = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy);
        v = '0;
        if (len_sq < radius_r * radius_r) begin
            v.hold = 1'b1;
            return v;
        end
        t = (ttt_r != 0) ? ttt_r : 1;
        vx = sat_pos(scale_trunc(dx, 256, t));
        vy = sat_pos(scale_trunc(dy, 256, t));
        s = abs64(vx) * abs64(vx) + abs64(vy) * abs64(vy);
        if (s > speed_r * speed_r) begin
            l = int_sqrt(s);
            vx = scale_trunc(vx, speed_r, l);
            vy = scale_trunc(vy, speed_r, l);
        end
        v.vx = vx[W-1:0];
        v.vy = vy[W-1:0];
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                pos_req_t p;
                p = pending_reqs.pop_front();
                expected_vel.push_back(arrive_velocity(p));
                s_tvalid <= 1'b1;
                s_tdata  <= p;
            end
            else s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= $urandom_range(99) >= snk_idle_pct;
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            vel_t e;
            results_seen++;
            if (expected_vel.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[W-1:0], '0);
            end
            else begin
                e = expected_vel.pop_front();
                if (e.hold) holds_seen++;
                if (m_tdata[W-1:0] !== e.vx) report_mismatch("vel_x", m_tdata[W-1:0], e.vx);
                if (m_tdata[2*W-1:W] !== e.vy)
                    report_mismatch("vel_y", m_tdata[2*W-1:W], e.vy);
                if (m_tuser !== e.hold) report_mismatch("hold", m_tuser, e.hold);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_vel.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_addr  <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            avel_pkg::CFG_RADIUS: radius_r = val;
            avel_pkg::CFG_TIME:   ttt_r = val[15:0];
            default:              speed_r = val;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [W-1:0] rnd_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed(24'($urandom_range(8191))) - 24'sd4096;
            2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
            default: return $signed(24'($urandom_range(131071))) - 24'sd65536;
        endcase
    endfunction

    task automatic queue_random(int n);
        pos_req_t p;
        int m;
        repeat (n) begin
            m = $urandom_range(3);
            p.tx = rnd_pos(m);
            p.ty = rnd_pos(m);
            p.ox = $urandom_range(3) == 0 ? p.tx + $signed(24'($urandom_range(15))) - 8
                                          : rnd_pos($urandom_range(3));
            p.oy = $urandom_range(3) == 0 ? p.ty + $signed(24'($urandom_range(15))) - 8
                                          : rnd_pos($urandom_range(3));
            pending_reqs.push_back(p);
        end
    endtask

    task automatic queue_one(int tx, int ty, int ox, int oy);
        pos_req_t p;
        p.tx = tx; p.ty = ty; p.ox = ox; p.oy = oy;
        pending_reqs.push_back(p);
    endtask

    initial begin
        rst_n = 0; cfg_valid = 0; cfg_addr = '0; cfg_data = '0;
        radius_r = 0; ttt_r = 256; speed_r = 23'h7fffff;
        src_idle_pct = 38; snk_idle_pct = 51;
        errors = 0; results_seen = 0; holds_seen = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, extremes, saturation
        queue_one(0, 0, 0, 0);
        queue_one(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
        queue_one(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
        queue_one(256, -256, 0, 0);
        wait_drained();
        // exactly on the radius, just inside
        write_reg(avel_pkg::CFG_RADIUS, 23'd500);
        write_reg(avel_pkg::CFG_TIME, 16'd0);
        write_reg(avel_pkg::CFG_SPEED, 23'd1000);
        queue_one(500, 0, 0, 0);
        queue_one(300, 400, 0, 0);
        queue_one(499, 0, 0, 0);
        queue_one(300, 399, 0, 0);
        queue_one(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
        queue_one(-700, 20, 0, 0);
        wait_drained();
        write_reg(avel_pkg::CFG_SPEED, 23'd0);
        write_reg(avel_pkg::CFG_TIME, 16'hffff);
        queue_one(10000, -3, 0, 0);
        queue_one(0, 0, 0, 0);
        queue_one(24'h7fffff, 0, 24'h800000, 0);
        wait_drained();
        write_reg(avel_pkg::CFG_RADIUS, 23'h7fffff);
        queue_one(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
        queue_one(1000, 1000, 0, 0);
        wait_drained();

        // random phases across settings and idling mixes
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin src_idle_pct = 51; snk_idle_pct = 38; end
            if (ph == 8) begin src_idle_pct = 0; snk_idle_pct = 0; end
            write_reg(avel_pkg::CFG_RADIUS, ph % 3 == 0 ? 23'd0 : 23'($urandom_range(20000)));
            write_reg(avel_pkg::CFG_TIME, ph % 4 == 1 ? 16'd1 : 16'($urandom_range(2000)));
            write_reg(avel_pkg::CFG_SPEED, ph % 4 == 2 ? 23'h7fffff : 23'($urandom));
            queue_random(125);
            wait_drained();
        end

        $display("covered %0d results (%0d held) over 12 register settings",
                 results_seen, holds_seen);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
